FILE: rtl/mre_pkg.sv
// Shared types, constants and helper functions for the matrix row operation engine.
// Depends on nothing; every other file in the block imports it.
package mre_pkg;

   localparam int DIM    = 8;
   localparam int CNT_W  = $clog2(DIM);
   localparam int ADDR_W = $clog2(DIM * DIM);
   localparam int DATA_W = 32;
   localparam int IDX_W  = 3;
   localparam int PROD_W = 2 * DATA_W;
   localparam int FRAC_W = 16;
   localparam int PQ_W   = PROD_W - FRAC_W;
   // Room for DIM scaled products without wrapping before the final saturation.
   localparam int ACC_W  = PQ_W + CNT_W;

   typedef enum logic [2:0] {
      FUNC_WRITE = 3'd0,
      FUNC_READ  = 3'd1,
      FUNC_SWAP  = 3'd2,
      FUNC_ADD   = 3'd3,
      FUNC_LOAD  = 3'd4,
      FUNC_PROD  = 3'd5,
      FUNC_SPLIT = 3'd6
   } func_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ_RD,
      S_READ_OUT,
      S_SWAP_RD,
      S_SWAP_WA,
      S_SWAP_WB,
      S_ADD_RD,
      S_ADD_MUL,
      S_ADD_WR,
      S_PROD_RD,
      S_PROD_MUL,
      S_PROD_ACC,
      S_PROD_OUT,
      S_SPLIT_RD,
      S_SPLIT_OUT
   } state_type;

   typedef enum logic [2:0] {
      WSEL_REQ,
      WSEL_RDA,
      WSEL_RDB,
      WSEL_SUM,
      WSEL_ZERO
   } wsel_type;

   typedef enum logic {
      BSEL_VAL,
      BSEL_VEC
   } bsel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      OSEL_RDA,
      OSEL_ACC,
      OSEL_ZERO
   } osel_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      wsel_type          wr_sel;
      logic              vec_we;
      logic [CNT_W-1:0]  vec_idx;
      logic              mul_en;
      bsel_type          mul_b_sel;
      acc_op_type        acc_op;
      logic              out_load;
      osel_type          out_sel;
      logic [IDX_W-1:0]  out_index;
      logic              out_last;
   } ctl_type;

   function automatic logic [ADDR_W-1:0] mat_addr(input logic [CNT_W-1:0] row,
                                                  input logic [CNT_W-1:0] col);
      return ADDR_W'(int'(row) * DIM + int'(col));
   endfunction

   // Clamp a wide signed sum to the signed 32-bit range.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-DATA_W:0] top_bits;
      top_bits = v[ACC_W-1:DATA_W-1];
      if ((&top_bits) || !(|top_bits)) begin
         return v[DATA_W-1:0];
      end
      return v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   endfunction

endpackage

FILE: rtl/mre_mat_ram.sv
// Matrix element store: one write port and two registered read ports.
// Depends on mre_pkg for the depth and widths.
module mre_mat_ram
   import mre_pkg::*;
(
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr_a,
   input  logic [ADDR_W-1:0]        rd_addr_b,
   output logic signed [DATA_W-1:0] rd_data_a,
   output logic signed [DATA_W-1:0] rd_data_b,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [DATA_W-1:0] wr_data
);

   logic signed [DATA_W-1:0] mem [DIM*DIM];
   logic signed [DATA_W-1:0] rd_a_ff;
   logic signed [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read so a waiting state can still use it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/mre_mac.sv
// Shared Q16.16 multiply-accumulate unit: registered multiplier, accumulator, saturation.
// Depends on mre_pkg for widths and the saturation function.
module mre_mac
   import mre_pkg::*;
(
   input  logic                     clock,
   input  logic                     mul_en,
   input  logic signed [DATA_W-1:0] mul_a,
   input  logic signed [DATA_W-1:0] mul_b,
   input  acc_op_type               acc_op,
   input  logic signed [DATA_W-1:0] addend,
   output logic signed [DATA_W-1:0] sum_sat,
   output logic signed [DATA_W-1:0] acc_sat
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PQ_W-1:0]   prod_q;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  sum;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Dropping the fraction bits of a two's complement product rounds toward minus infinity.
   assign prod_q = prod_ff[PROD_W-1:FRAC_W];

   always_comb begin
      case (acc_op)
         ACC_CLEAR: acc_in = '0;
         ACC_ADD:   acc_in = acc_ff + ACC_W'(prod_q);
         default:   acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign sum     = ACC_W'(addend) + ACC_W'(prod_q);
   assign sum_sat = sat32(sum);
   assign acc_sat = sat32(acc_ff);

endmodule

FILE: rtl/mre_seq.sv
// Command sequencer: decodes each request and steps the store and the shared unit.
// Depends on mre_pkg for the state, command and control types.
module mre_seq
   import mre_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [2:0]       req_func,
   input  logic [IDX_W-1:0] req_row,
   input  logic [IDX_W-1:0] req_col,
   input  logic             out_free,
   output logic             req_ready,
   output ctl_type          ctl
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] c_ff, c_in;
   logic             ok_ff, ok_in;
   logic             row_ok, col_ok;
   logic             i_last, j_last;
   logic [CNT_W-1:0] rr, cc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         r_ff     <= '0;
         c_ff     <= '0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         ok_ff    <= ok_in;
      end
   end

   assign row_ok = int'(req_row) < DIM;
   assign col_ok = int'(req_col) < DIM;
   assign i_last = (i_ff == CNT_W'(DIM - 1));
   assign j_last = (j_ff == CNT_W'(DIM - 1));
   assign rr     = CNT_W'(r_ff);
   assign cc     = CNT_W'(c_ff);

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      ok_in     = ok_ff;
      req_ready = 1'b0;
      ctl       = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               r_in  = req_row;
               c_in  = req_col;
               ok_in = row_ok && col_ok;
               i_in  = '0;
               j_in  = '0;
               case (func_type'(req_func))
                  FUNC_WRITE: begin
                     if (row_ok && col_ok) begin
                        ctl.wr_en   = 1'b1;
                        ctl.wr_addr = mat_addr(CNT_W'(req_row), CNT_W'(req_col));
                        ctl.wr_sel  = WSEL_REQ;
                     end
                  end
                  FUNC_READ: begin
                     state_in = (row_ok && col_ok) ? S_READ_RD : S_READ_OUT;
                  end
                  FUNC_SWAP: begin
                     if (row_ok && col_ok && (req_row != req_col)) begin
                        state_in = S_SWAP_RD;
                     end
                  end
                  FUNC_ADD: begin
                     if (row_ok && col_ok) begin
                        state_in = S_ADD_RD;
                     end
                  end
                  FUNC_LOAD: begin
                     if (col_ok) begin
                        ctl.vec_we  = 1'b1;
                        ctl.vec_idx = CNT_W'(req_col);
                     end
                  end
                  FUNC_PROD: begin
                     ctl.acc_op = ACC_CLEAR;
                     state_in   = S_PROD_RD;
                  end
                  FUNC_SPLIT: begin
                     state_in = S_SPLIT_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_READ_RD: begin
            ctl.rd_en     = 1'b1;
            ctl.rd_addr_a = mat_addr(rr, cc);
            ctl.rd_addr_b = mat_addr(rr, cc);
            state_in      = S_READ_OUT;
         end

         S_READ_OUT: begin
            if (out_free) begin
               ctl.out_load  = 1'b1;
               ctl.out_sel   = ok_ff ? OSEL_RDA : OSEL_ZERO;
               ctl.out_index = r_ff;
               ctl.out_last  = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_SWAP_RD: begin
            ctl.rd_en     = 1'b1;
            ctl.rd_addr_a = mat_addr(rr, i_ff);
            ctl.rd_addr_b = mat_addr(cc, i_ff);
            state_in      = S_SWAP_WA;
         end

         S_SWAP_WA: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = mat_addr(cc, i_ff);
            ctl.wr_sel  = WSEL_RDA;
            state_in    = S_SWAP_WB;
         end

         S_SWAP_WB: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = mat_addr(rr, i_ff);
            ctl.wr_sel  = WSEL_RDB;
            i_in        = i_ff + 1'b1;
            state_in    = i_last ? S_IDLE : S_SWAP_RD;
         end

         S_ADD_RD: begin
            ctl.rd_en     = 1'b1;
            ctl.rd_addr_a = mat_addr(rr, i_ff);
            ctl.rd_addr_b = mat_addr(cc, i_ff);
            state_in      = S_ADD_MUL;
         end

         S_ADD_MUL: begin
            ctl.mul_en    = 1'b1;
            ctl.mul_b_sel = BSEL_VAL;
            state_in      = S_ADD_WR;
         end

         S_ADD_WR: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = mat_addr(cc, i_ff);
            ctl.wr_sel  = WSEL_SUM;
            i_in        = i_ff + 1'b1;
            state_in    = i_last ? S_IDLE : S_ADD_RD;
         end

         S_PROD_RD: begin
            ctl.rd_en     = 1'b1;
            ctl.rd_addr_a = mat_addr(i_ff, j_ff);
            ctl.rd_addr_b = mat_addr(i_ff, j_ff);
            state_in      = S_PROD_MUL;
         end

         S_PROD_MUL: begin
            ctl.mul_en    = 1'b1;
            ctl.mul_b_sel = BSEL_VEC;
            ctl.vec_idx   = j_ff;
            state_in      = S_PROD_ACC;
         end

         S_PROD_ACC: begin
            ctl.acc_op = ACC_ADD;
            j_in       = j_ff + 1'b1;
            state_in   = j_last ? S_PROD_OUT : S_PROD_RD;
         end

         S_PROD_OUT: begin
            if (out_free) begin
               ctl.out_load  = 1'b1;
               ctl.out_sel   = OSEL_ACC;
               ctl.out_index = IDX_W'(i_ff);
               ctl.out_last  = i_last;
               ctl.acc_op    = ACC_CLEAR;
               i_in          = i_ff + 1'b1;
               j_in          = '0;
               state_in      = i_last ? S_IDLE : S_PROD_RD;
            end
         end

         S_SPLIT_RD: begin
            ctl.rd_en     = 1'b1;
            ctl.rd_addr_a = mat_addr(i_ff, i_ff);
            ctl.rd_addr_b = mat_addr(i_ff, i_ff);
            state_in      = S_SPLIT_OUT;
         end

         S_SPLIT_OUT: begin
            if (out_free) begin
               ctl.out_load  = 1'b1;
               ctl.out_sel   = OSEL_RDA;
               ctl.out_index = IDX_W'(i_ff);
               ctl.out_last  = i_last;
               ctl.wr_en     = 1'b1;
               ctl.wr_addr   = mat_addr(i_ff, i_ff);
               ctl.wr_sel    = WSEL_ZERO;
               i_in          = i_ff + 1'b1;
               state_in      = i_last ? S_IDLE : S_SPLIT_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/matrix_row_operation_engine_unit.sv
// Matrix row operation engine: DIM x DIM Q16.16 matrix and DIM-entry vector, one request at a time.
// Requests are stepped through the matrix store's registered read ports and one shared
// multiplier. A read registers its address in S_READ_RD and loads its result in S_READ_OUT,
// which waits while the result register is full and rsp_tready is low.
// Reset (synchronous, active high) idles the sequencer and empties the result register;
// the matrix and vector stores are not cleared and hold garbage until written.
module matrix_row_operation_engine_unit
   import mre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // row_index [2:0], col_index [5:3], value [37:6], zero pad
   input  logic [2:0]  req_tuser,  // func [2:0]
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // result_value [31:0], result_index [34:32], zero pad
   output logic        rsp_tlast
);

   // Request fields.
   logic [IDX_W-1:0]         req_row_index;
   logic [IDX_W-1:0]         req_col_index;
   logic signed [DATA_W-1:0] req_value;

   assign req_row_index = req_tdata[2:0];
   assign req_col_index = req_tdata[5:3];
   assign req_value     = req_tdata[37:6];

   ctl_type ctl;
   logic    out_free;
   logic    req_accept;

   // The scale factor of a row add is kept for the whole sweep.
   logic signed [DATA_W-1:0] value_ff;

   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         value_ff <= req_value;
      end
   end

   // Sequencer: owns the command decode and the row and column counters.
   mre_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .req_row   (req_row_index),
      .req_col   (req_col_index),
      .out_free  (out_free),
      .req_ready (req_tready),
      .ctl       (ctl)
   );

   // Vector store. It is small and read at a single counter-chosen place, so it lives
   // in flip-flops and feeds the multiplier directly.
   logic signed [DATA_W-1:0] vec_ff [DIM];

   always_ff @(posedge clock) begin
      if (ctl.vec_we) begin
         vec_ff[ctl.vec_idx] <= req_value;
      end
   end

   // Matrix store.
   logic signed [DATA_W-1:0] rd_data_a;
   logic signed [DATA_W-1:0] rd_data_b;
   logic signed [DATA_W-1:0] wr_data;
   logic signed [DATA_W-1:0] sum_sat;
   logic signed [DATA_W-1:0] acc_sat;
   logic signed [DATA_W-1:0] mul_b;

   always_comb begin
      case (ctl.wr_sel)
         WSEL_REQ:  wr_data = req_value;
         WSEL_RDA:  wr_data = rd_data_a;
         WSEL_RDB:  wr_data = rd_data_b;
         WSEL_SUM:  wr_data = sum_sat;
         default:   wr_data = '0;
      endcase
   end

   mre_mat_ram u_mat_ram (
      .clock     (clock),
      .rd_en     (ctl.rd_en),
      .rd_addr_a (ctl.rd_addr_a),
      .rd_addr_b (ctl.rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .wr_en     (ctl.wr_en),
      .wr_addr   (ctl.wr_addr),
      .wr_data   (wr_data)
   );

   // Shared multiply-accumulate unit. Operand A is always the element read from port A;
   // operand B is the row add scale or the vector entry for the current column.
   assign mul_b = (ctl.mul_b_sel == BSEL_VEC) ? vec_ff[ctl.vec_idx] : value_ff;

   mre_mac u_mac (
      .clock   (clock),
      .mul_en  (ctl.mul_en),
      .mul_a   (rd_data_a),
      .mul_b   (mul_b),
      .acc_op  (ctl.acc_op),
      .addend  (rd_data_b),
      .sum_sat (sum_sat),
      .acc_sat (acc_sat)
   );

   // Result register. It frees up in the same cycle the downstream side takes its result,
   // so the sequencer can load the next result without a bubble.
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic                     rsp_last_ff;
   logic signed [DATA_W-1:0] out_value;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      case (ctl.out_sel)
         OSEL_RDA: out_value = rd_data_a;
         OSEL_ACC: out_value = acc_sat;
         default:  out_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_value_ff <= out_value;
         rsp_index_ff <= ctl.out_index;
         rsp_last_ff  <= ctl.out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: test/matrix_row_checker.sv
// Scoreboard for the matrix row operation engine: watches the request and result channels,
// keeps its own matrix and vector copy, predicts each result and compares it field by field.
// Depends on mre_pkg for sizes and command codes.
module matrix_row_checker
   import mre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // row_index [2:0], col_index [5:3], value [37:6], zero pad
   input  logic [2:0]  req_tuser,   // func [2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // result_value [31:0], result_index [34:32], zero pad
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q_HI = 64'sd2147483647;
   localparam longint Q_LO = -64'sd2147483648;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [IDX_W-1:0]         index;
      logic                     last;
   } row_result_type;

   logic signed [DATA_W-1:0] mat_copy [DIM][DIM];
   logic signed [DATA_W-1:0] vec_copy [DIM];
   row_result_type           result_q [$];
   int                       errors_seen = 0;

   // Q16.16 product, floor of the full product over 2^16.
   function automatic longint fx_mul(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC_W;
   endfunction

   function automatic logic signed [DATA_W-1:0] fx_clamp(input longint v);
      if (v > Q_HI) return DATA_W'(Q_HI);
      if (v < Q_LO) return DATA_W'(Q_LO);
      return DATA_W'(v);
   endfunction

   function automatic void push_result(input logic signed [DATA_W-1:0] v, input int idx,
                                       input logic last);
      row_result_type res;
      res.value = v;
      res.index = IDX_W'(idx);
      res.last  = last;
      result_q.push_back(res);
   endfunction

   // Updates the matrix or vector copy for one accepted request and queues what it produces.
   function automatic void apply_request(input logic [2:0] code, input int r, input int c,
                                         input logic signed [DATA_W-1:0] v);
      func_type                 f;
      logic signed [DATA_W-1:0] t;
      longint                   acc;
      f = func_type'(code);
      case (f)
         FUNC_WRITE: mat_copy[r][c] = v;
         FUNC_READ:  push_result(mat_copy[r][c], r, 1'b1);
         FUNC_SWAP: begin
            if (r != c) begin
               for (int i = 0; i < DIM; i++) begin
                  t              = mat_copy[c][i];
                  mat_copy[c][i] = mat_copy[r][i];
                  mat_copy[r][i] = t;
               end
            end
         end
         FUNC_ADD: begin
            // Element by element, so a row added to itself reads each entry before it changes.
            for (int i = 0; i < DIM; i++)
               mat_copy[c][i] = fx_clamp(longint'(mat_copy[c][i]) + fx_mul(mat_copy[r][i], v));
         end
         FUNC_LOAD: vec_copy[c] = v;
         FUNC_PROD: begin
            for (int i = 0; i < DIM; i++) begin
               acc = 0;
               for (int j = 0; j < DIM; j++)
                  acc += fx_mul(mat_copy[i][j], vec_copy[j]);
               push_result(fx_clamp(acc), i, i == DIM - 1);
            end
         end
         FUNC_SPLIT: begin
            for (int i = 0; i < DIM; i++) begin
               push_result(mat_copy[i][i], i, i == DIM - 1);
               mat_copy[i][i] = '0;
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      row_result_type want;
      if (reset) begin
         result_q.delete();
         error_count <= 0;
         pending     <= 0;
      end else begin
         // Results are checked before the request of the same edge is applied; no request
         // can produce a result on the edge that accepts it.
         if (rsp_tvalid && rsp_tready) begin
            if (result_q.size() == 0) begin
               errors_seen++;
               $display("%0t: unexpected result, expected none, got value %h index %0d last %0b",
                        $time, rsp_tdata[31:0], rsp_tdata[34:32], rsp_tlast);
            end else begin
               want = result_q.pop_front();
               if (rsp_tdata[31:0] !== want.value) begin
                  errors_seen++;
                  $display("%0t: result_value mismatch, expected %h, got %h",
                           $time, want.value, rsp_tdata[31:0]);
               end
               if (rsp_tdata[34:32] !== want.index) begin
                  errors_seen++;
                  $display("%0t: result_index mismatch, expected %0d, got %0d",
                           $time, want.index, rsp_tdata[34:32]);
               end
               if (rsp_tlast !== want.last) begin
                  errors_seen++;
                  $display("%0t: last mismatch, expected %0b, got %0b",
                           $time, want.last, rsp_tlast);
               end
               if (rsp_tdata[39:35] !== 5'd0) begin
                  errors_seen++;
                  $display("%0t: pad bits mismatch, expected 0, got %h",
                           $time, rsp_tdata[39:35]);
               end
            end
         end
         if (req_tvalid && req_tready)
            apply_request(req_tuser, int'(req_tdata[2:0]), int'(req_tdata[5:3]),
                          req_tdata[37:6]);
         error_count <= errors_seen;
         pending     <= result_q.size();
      end
   end

endmodule

FILE: test/testbench.sv
// Top of the matrix row operation engine testbench: clock, reset, request stimulus,
// result-side back-pressure, watchdog and verdict. Depends on mre_pkg, the engine and
// matrix_row_checker, which does all prediction and comparison.
module testbench
   import mre_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Command code with no meaning; the engine must drop it without a result.
   localparam logic [2:0] FUNC_UNUSED = 3'd7;

   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_ITEMS   = 220;
   localparam int QUIET_TAIL     = 60;   // last random requests, sent with no idling at all
   localparam int LONG_HOLD      = 200;  // cycles the result side refuses during back-pressure
   localparam int TAIL_CYCLES    = 60;   // covers a swap or row add still running at the end
   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // row_index [2:0], col_index [5:3], value [37:6], zero pad
   logic [2:0]  req_tuser;   // func [2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // result_value [31:0], result_index [34:32], zero pad
   logic        rsp_tlast;

   int error_count;
   int pending;
   int idle_cycles = 0;
   bit idle_enabled;
   // The stimulus asks for a long result-side hold by bumping hold_asked; the receiver
   // process serves it and catches hold_served up. Each counter has a single writer.
   int hold_asked;
   int hold_served;

   matrix_row_operation_engine_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   matrix_row_checker row_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .error_count (error_count),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Value mix: mostly modest Q16.16 numbers so that products stay in range, with a share
   // of full-range words and the extremes so that saturation is reached as well.
   function automatic logic [31:0] pick_value();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               3:       return 32'h0001_0000;
               default: return 32'hFFFF_0000;
            endcase
         end
         1, 2:    return raw;
         3, 4, 5: return {{13{raw[18]}}, raw[18:0]};   // within +/- 4.0
         default: return {{8{raw[23]}}, raw[23:0]};    // within +/- 128.0
      endcase
   endfunction

   // Row-add scale: usually within +/- 1.0 so that rows do not all pin at the rails.
   function automatic logic [31:0] pick_scale();
      logic [31:0] raw;
      raw = $urandom;
      if ($urandom_range(0, 3) == 0) return pick_value();
      return {{15{raw[16]}}, raw[16:0]};
   endfunction

   // Offers one request and returns on the edge that accepts it. The valid stays high
   // between back-to-back requests; a gap lowers it only when idling is allowed.
   task automatic send_request(input logic [2:0] code, input logic [2:0] r,
                               input logic [2:0] c, input logic [31:0] v);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {2'b00, v, c, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Holds the request side until every predicted result has been delivered. The first
   // edge lets the checker take in the request accepted on the current edge.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Result-side back-pressure: short random refusals, one long hold on request, and none
   // once idling has been switched off for the tail of the run.
   initial begin
      rsp_tready  = 1'b0;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_served = hold_asked;
         end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or result accepted for %0d cycles", $time, idle_cycles);
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      int          n;
      int          pick;
      logic [2:0]  r;
      logic [2:0]  c;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      idle_enabled = 1'b1;
      hold_asked   = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The stores power up with garbage, so every entry is written before anything that
      // reads it. Vector entries stay modest here to keep the first products meaningful.
      for (int i = 0; i < DIM; i++)
         for (int j = 0; j < DIM; j++)
            send_request(FUNC_WRITE, 3'(i), 3'(j), pick_value());
      for (int j = 0; j < DIM; j++)
         send_request(FUNC_LOAD, 3'd0, 3'(j), {{13{1'b0}}, 19'($urandom)} - 32'h0004_0000);

      // Directed part: rails of every field, each command and each corner of the commands.
      send_request(FUNC_WRITE, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send_request(FUNC_WRITE, 3'd7, 3'd7, 32'h8000_0000);
      send_request(FUNC_WRITE, 3'd3, 3'd5, 32'h0000_0000);
      send_request(FUNC_READ,  3'd0, 3'd0, 32'hFFFF_FFFF);
      send_request(FUNC_READ,  3'd7, 3'd7, 32'h0000_0000);
      send_request(FUNC_READ,  3'd3, 3'd5, 32'h1234_5678);
      send_request(FUNC_LOAD,  3'd7, 3'd0, 32'h7FFF_FFFF);
      send_request(FUNC_LOAD,  3'd0, 3'd7, 32'h8000_0000);
      send_request(FUNC_PROD,  3'd0, 3'd0, 32'h0000_0000);
      // A row swapped with itself must leave the matrix alone.
      send_request(FUNC_SWAP,  3'd2, 3'd2, 32'h0000_0000);
      send_request(FUNC_SWAP,  3'd0, 3'd7, 32'h0000_0000);
      send_request(FUNC_READ,  3'd7, 3'd0, 32'h0000_0000);
      // A row added to itself with scale 1.0 doubles every entry, saturating at the rails.
      send_request(FUNC_ADD,   3'd4, 3'd4, 32'h0001_0000);
      send_request(FUNC_ADD,   3'd1, 3'd6, 32'h7FFF_FFFF);
      send_request(FUNC_ADD,   3'd6, 3'd1, 32'h8000_0000);
      send_request(FUNC_READ,  3'd4, 3'd4, 32'h0000_0000);
      send_request(FUNC_READ,  3'd6, 3'd0, 32'h0000_0000);
      send_request(FUNC_SPLIT, 3'd0, 3'd0, 32'h0000_0000);
      // The split cleared the diagonal, so this read must return zero.
      send_request(FUNC_READ,  3'd0, 3'd0, 32'h0000_0000);
      send_request(FUNC_UNUSED, 3'd5, 3'd2, 32'hDEAD_BEEF);
      send_request(FUNC_PROD,  3'd7, 3'd7, 32'hFFFF_FFFF);
      wait_drained();

      n = 0;
      while (n < RANDOM_ITEMS) begin
         if (n == RANDOM_ITEMS - QUIET_TAIL) idle_enabled = 1'b0;

         // Back-pressure: the result side stops while requests keep coming, so the
         // engine's output fills and it has to stall its request side.
         if (n == 80) begin
            hold_asked++;
            send_request(FUNC_PROD, 3'd0, 3'd0, 32'h0000_0000);
            for (int k = 0; k < 4; k++)
               send_request(FUNC_READ, 3'($urandom), 3'($urandom), $urandom);
            send_request(FUNC_SPLIT, 3'd0, 3'd0, 32'h0000_0000);
            send_request(FUNC_PROD, 3'd0, 3'd0, 32'h0000_0000);
         end
         if (n == 140) wait_drained();

         pick = $urandom_range(0, 99);
         r    = 3'($urandom);
         c    = 3'($urandom);
         n++;
         if (pick < 24) begin
            send_request(FUNC_WRITE, r, c, pick_value());
         end else if (pick < 42) begin
            send_request(FUNC_READ, r, c, $urandom);
         end else if (pick < 52) begin
            send_request(FUNC_SWAP, r, c, $urandom);
         end else if (pick < 66) begin
            send_request(FUNC_ADD, r, c, pick_scale());
         end else if (pick < 76) begin
            send_request(FUNC_LOAD, r, c, pick_value());
         end else if (pick < 84) begin
            send_request(FUNC_PROD, r, c, $urandom);
         end else if (pick < 90) begin
            send_request(FUNC_SPLIT, r, c, $urandom);
         end else begin
            // Ignored by the engine, so it does not count as a request.
            send_request(FUNC_UNUSED, r, c, $urandom);
            n--;
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/mre_pkg.sv
rtl/mre_mat_ram.sv
rtl/mre_mac.sv
rtl/mre_seq.sv
rtl/matrix_row_operation_engine_unit.sv
test/matrix_row_checker.sv
test/testbench.sv
